/* rtl/twest_pkg.sv */
`timescale 1ns / 1ps

package twest_pkg;

  localparam int TIME_W      = 32;
  localparam int ENERGY_W    = 32;
  localparam int MIN_E_W     = 33;
  localparam int SUM_W       = 48;
  localparam int USE_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int MAX_WINDOWS = 2;
  localparam int WIN_IDX_W   = 1;

  localparam int NUM_WINDOWS_DEFAULT = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN0_START = 3'd0,
    REG_WIN0_END   = 3'd1,
    REG_WIN1_START = 3'd2,
    REG_WIN1_END   = 3'd3,
    REG_WIN_USE    = 3'd4,
    REG_MIN_PHOTON = 3'd5,
    REG_MIN_TOTAL  = 3'd6
  } twest_reg_t;

  // What one window does with the current hit.
  typedef struct packed {
    logic             pass;
    logic [SUM_W-1:0] sum_next;
  } twest_win_res_t;

endpackage

/* rtl/twest_window.sv */
`timescale 1ns / 1ps

module twest_window (
  input  logic signed [twest_pkg::TIME_W-1:0]   win_start,
  input  logic signed [twest_pkg::TIME_W-1:0]   win_end,
  input  logic                                  enable,
  input  logic                                  hit_ok,
  input  logic signed [twest_pkg::TIME_W-1:0]   photon_time,
  input  logic        [twest_pkg::ENERGY_W-1:0] photon_energy,
  input  logic        [twest_pkg::SUM_W-1:0]    sum,
  input  logic        [twest_pkg::SUM_W-1:0]    min_total,
  output twest_pkg::twest_win_res_t             res
);
  import twest_pkg::*;

  logic             in_win;
  logic             add_en;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  // Saturating add of the hit energy to the window sum.
  assign in_win   = (photon_time >= win_start) && (photon_time <= win_end);
  assign add_en   = enable && hit_ok && in_win;
  assign sum_wide = {1'b0, sum} + {{(SUM_W + 1 - ENERGY_W){1'b0}}, photon_energy};
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  always_comb begin
    res.sum_next = add_en ? sum_sat : sum;
    res.pass     = add_en && (sum_sat > min_total);
  end

endmodule

/* rtl/time_window_energy_sum_trigger.sv */
`timescale 1ns / 1ps
// A closing item's result goes from the input register into the output register.
// Throughput: one item per cycle save stalls; window compare and accumulate are combinational.
// A closing item stalls only while the previous result is still waiting at the output.
// Reset clears the pipeline, the window sums, the pass flag and index, and sets every
// configuration register to its reset value (all zero, minimum photon energy minus one).
module time_window_energy_sum_trigger #(
  parameter int NUM_WINDOWS = twest_pkg::NUM_WINDOWS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Hit requests.
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    holds_photon,
  input  logic signed [twest_pkg::TIME_W-1:0]     photon_time,
  input  logic        [twest_pkg::ENERGY_W-1:0]   photon_energy,
  input  logic                                    last_of_event,
  // Trigger decisions.
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    event_pass,
  output logic        [twest_pkg::WIN_IDX_W-1:0]  passing_window,
  // Configuration writes.
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [twest_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [twest_pkg::CFG_DATA_W-1:0] cfg_data
);
  import twest_pkg::*;

  // Configuration registers. Writes are always taken; the host must write only while
  // the block is idle, so no item sees a half-updated setup. The block does not enforce it.
  logic signed [TIME_W-1:0]  win_start [MAX_WINDOWS];
  logic signed [TIME_W-1:0]  win_end   [MAX_WINDOWS];
  logic        [USE_W-1:0]   win_use;
  logic signed [MIN_E_W-1:0] min_photon;
  logic        [SUM_W-1:0]   min_total;

  // Input register: the request that is being worked on this cycle.
  logic                      item_valid;
  logic                      item_hold;
  logic signed [TIME_W-1:0]  item_time;
  logic        [ENERGY_W-1:0] item_energy;
  logic                      item_last;

  // Event state.
  logic [SUM_W-1:0]     sums [NUM_WINDOWS];
  logic                 passed_flag;
  logic [WIN_IDX_W-1:0] first_idx;

  logic                 hit_ok;
  logic                 advance;
  logic                 passed_next;
  logic [WIN_IDX_W-1:0] first_idx_next;
  twest_win_res_t       win_res [NUM_WINDOWS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        win_start[i] <= '0;
        win_end[i]   <= '0;
      end
      win_use    <= '0;
      min_photon <= '1;
      min_total  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIN0_START: win_start[0] <= cfg_data[TIME_W-1:0];
        REG_WIN0_END:   win_end[0]   <= cfg_data[TIME_W-1:0];
        REG_WIN1_START: win_start[1] <= cfg_data[TIME_W-1:0];
        REG_WIN1_END:   win_end[1]   <= cfg_data[TIME_W-1:0];
        REG_WIN_USE:    win_use      <= cfg_data[USE_W-1:0];
        REG_MIN_PHOTON: min_photon   <= cfg_data[MIN_E_W-1:0];
        REG_MIN_TOTAL:  min_total    <= cfg_data[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // The item in the input register moves on unless it closes an event and
  // the previous decision has not yet been taken. Non-closing hits keep
  // flowing while a decision waits at the output.
  assign advance  = !item_last || !out_valid || out_ready;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_hold   <= holds_photon;
      item_time   <= photon_time;
      item_energy <= photon_energy;
      item_last   <= last_of_event;
    end
  end

  // The energy cut compares the unsigned energy against a signed threshold,
  // so a threshold of minus one lets every hit through.
  assign hit_ok = item_hold && ($signed({1'b0, item_energy}) > min_photon);

  // One compare-and-accumulate slice per window. Windows beyond the number
  // in use are disabled; a count above NUM_WINDOWS enables all of them.
  for (genvar g = 0; g < NUM_WINDOWS; g++) begin : g_win
    twest_window u_window (
      .win_start     (win_start[g]),
      .win_end       (win_end[g]),
      .enable        (win_use > USE_W'(g)),
      .hit_ok        (hit_ok),
      .photon_time   (item_time),
      .photon_energy (item_energy),
      .sum           (sums[g]),
      .min_total     (min_total),
      .res           (win_res[g])
    );
  end

  // Only the first window to pass in an event is latched; the lower index
  // wins when two windows pass on the same hit.
  always_comb begin
    passed_next    = passed_flag;
    first_idx_next = first_idx;
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      if (!passed_next && win_res[i].pass) begin
        passed_next    = 1'b1;
        first_idx_next = WIN_IDX_W'(i);
      end
    end
  end

  // Event state: a closing item reports and then clears everything, the hit
  // it carries already counted in the decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        sums[i] <= '0;
      end
      passed_flag <= 1'b0;
      first_idx   <= '0;
    end else if (item_valid && advance) begin
      if (item_last) begin
        for (int i = 0; i < NUM_WINDOWS; i++) begin
          sums[i] <= '0;
        end
        passed_flag <= 1'b0;
        first_idx   <= '0;
      end else begin
        for (int i = 0; i < NUM_WINDOWS; i++) begin
          sums[i] <= win_res[i].sum_next;
        end
        passed_flag <= passed_next;
        first_idx   <= first_idx_next;
      end
    end
  end

  // Output register holding one decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_valid && advance && item_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance && item_last) begin
      event_pass     <= passed_next;
      passing_window <= passed_next ? first_idx_next : '0;
    end
  end

  // A closed event leaves no pass flag behind.
  a_clear_after_close: assert property (@(posedge clk) disable iff (rst)
    (item_valid && advance && item_last) |=> !passed_flag)
    else $error("pass flag survived the end of an event");

  // The latched index is zero whenever no window has passed.
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    !passed_flag |-> (first_idx == '0))
    else $error("first pass index set without a pass");

  // A failed event always reports window zero.
  a_fail_idx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_pass) |-> (passing_window == '0))
    else $error("failed event reports a nonzero window");

  // The pass flag only comes up from a hit being worked on.
  a_rise_from_hit: assert property (@(posedge clk) disable iff (rst)
    $rose(passed_flag) |-> $past(item_valid && item_hold && !item_last))
    else $error("pass flag set without a hit");

  // An empty input register always takes a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> in_ready)
    else $error("input stalled while empty");

endmodule
